// File: sv/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// File: sv/psvm_pkg.sv
// shared types, constants and functions of the sine voice mixer
package psvm_pkg;
    localparam int VOICES_DEF       = 10;
    localparam int SINE_ENTRIES_DEF = 1024;
    localparam int NOTE_COUNT       = 36;
    localparam logic [5:0] SILENT_NOTE = 6'd36;
    localparam logic [15:0] RELEASE_RESET = 16'd5000;

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_PRESS   = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  key_code;
    } t_req;

    typedef struct packed {
        logic [16:0] sample;
    } t_res;

    // controller to datapath commands
    typedef struct packed {
        logic        load;      // capture request
        logic        press;     // apply press on captured note
        logic        release_k; // apply release on captured note
        logic        clr_sum;
        logic        v_start;   // start voice walk step (stage 0)
        logic        finish;    // clamp, advance counter, present result
    } t_cmd;

    typedef struct packed {
        logic        walk_done;
    } t_sts;

    typedef logic [NOTE_COUNT:0][31:0] t_inc_tab;

    function automatic logic [5:0] note_of_key(input logic [7:0] c);
        logic [5:0] n;
        n = SILENT_NOTE;
        case (c)
            8'h71: n = 6'd0;  8'h32: n = 6'd1;  8'h77: n = 6'd2;  8'h33: n = 6'd3;
            8'h65: n = 6'd4;  8'h72: n = 6'd5;  8'h35: n = 6'd6;  8'h74: n = 6'd7;
            8'h36: n = 6'd8;  8'h79: n = 6'd9;  8'h37: n = 6'd10; 8'h75: n = 6'd11;
            8'h69: n = 6'd12; 8'h39: n = 6'd13; 8'h6f: n = 6'd14; 8'h30: n = 6'd15;
            8'h70: n = 6'd16; 8'h3c: n = 6'd17; 8'h61: n = 6'd18; 8'h7a: n = 6'd19;
            8'h73: n = 6'd20; 8'h78: n = 6'd21; 8'h64: n = 6'd22; 8'h63: n = 6'd23;
            8'h76: n = 6'd24; 8'h67: n = 6'd25; 8'h62: n = 6'd26; 8'h68: n = 6'd27;
            8'h6e: n = 6'd28; 8'h6d: n = 6'd29; 8'h6b: n = 6'd30; 8'h2c: n = 6'd31;
            8'h6c: n = 6'd32; 8'h2e: n = 6'd33; 8'h3b: n = 6'd34; 8'h2f: n = 6'd35;
            default: n = SILENT_NOTE;
        endcase
        return n;
    endfunction

    // increment table, worked out at elaboration
    function automatic logic [31:0] note_inc(input logic [5:0] note);
        logic [63:0] v;
        v = 64'd25461073;
        if (note >= 6'(NOTE_COUNT)) return 32'd0;
        for (int k = 0; k < NOTE_COUNT; k++) begin
            if (k < int'(note)) v = (v * 64'd1137589835 + 64'd536870912) >> 30;
        end
        return v[31:0];
    endfunction

    function automatic t_inc_tab build_inc_tab();
        t_inc_tab tab;
        for (int n = 0; n <= NOTE_COUNT; n++) tab[n] = note_inc(6'(n));
        return tab;
    endfunction

    localparam t_inc_tab INC_TAB = build_inc_tab();
endpackage

// File: sv/psvm_if.sv
// valid/ready channel interface
interface psvm_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: sv/psvm_ctrl.sv
// controller: sequences press, release and tick work
module psvm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic [1:0]      i_op,
    input  logic            i_out_busy,
    input  psvm_pkg::t_sts  i_sts,
    output psvm_pkg::t_cmd  o_cmd
);
    import psvm_pkg::*;
`include "assert_macros.svh"

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_FIN  = 3'd3;

    logic [2:0] r_state, n_state;
    logic [1:0] r_op, n_op;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_op = r_op;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_op = i_op;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                unique case (r_op)
                    OP_TICK: begin
                        o_cmd.clr_sum = 1'b1;
                        o_cmd.v_start = 1'b1;
                        n_state = S_WALK;
                    end
                    OP_PRESS: begin
                        o_cmd.press = 1'b1;
                        n_state = S_IDLE;
                    end
                    OP_RELEASE: begin
                        o_cmd.release_k = 1'b1;
                        n_state = S_IDLE;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_WALK: begin
                if (i_sts.walk_done) n_state = S_FIN;
            end
            S_FIN: begin
                if (!i_out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op <= OP_TICK;
        end else begin
            r_state <= n_state;
            r_op <= n_op;
        end
    end

    `ASSERT_NEXT(a_load_dec, i_clk, i_rst_n, o_cmd.load, r_state == S_DEC)
    `ASSERT_IMPL(a_fin_free, i_clk, i_rst_n, !(o_cmd.finish && i_out_busy))
    `ASSERT_NEXT(a_walk_go, i_clk, i_rst_n, o_cmd.v_start, r_state == S_WALK)
endmodule

// File: sv/psvm_dp.sv
// datapath: voice state, phase, sine, gain and mix
module psvm_dp #(
    parameter int VOICES = psvm_pkg::VOICES_DEF,
    parameter int SINE_ENTRIES = psvm_pkg::SINE_ENTRIES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  psvm_pkg::t_cmd  i_cmd,
    input  logic [7:0]      i_key_code,
    input  logic            i_cfg_we,
    input  logic [15:0]     i_cfg_data,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output logic [16:0]     o_sample,
    output psvm_pkg::t_sts  o_sts
);
    import psvm_pkg::*;
`include "assert_macros.svh"

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int IW = $clog2(SINE_ENTRIES);
    localparam int NST = 8;
    localparam int SW = $clog2(NST + 1);

    logic [15:0]       r_rel_len;
    logic [31:0]       r_cnt;
    logic [VOICES-1:0] r_open, r_held;
    logic [5:0]        r_note [VOICES];
    logic [31:0]       r_rtime [VOICES];
    logic [5:0]        r_knote;
    logic [VW-1:0]     r_v;
    logic [SW-1:0]     r_st;
    logic              r_busy;
    logic signed [20:0] r_sum;
    logic              r_ov;
    logic [16:0]       r_os;

    // per-voice pipeline registers (one voice walked at a time)
    logic [31:0] r_inc, r_ph;
    logic [IW-1:0] r_idx;
    logic [1:0]  r_q;
    logic [16:0] r_t, r_t2, r_r;
    logic signed [13:0] r_s;
    logic [15:0] r_g;
    logic        r_act, r_hld, r_dead;

    // fade gain divide: shift and subtract, one quotient bit a cycle
    logic [28:0] r_rem, r_dsh;
    logic [12:0] r_quo;
    logic        r_neg;
    logic [3:0]  r_dk;

    logic [IW+1:0] four_i;
    logic [IW+16:0] t_wide;
    logic [16:0]   t_raw;
    logic [33:0]   m1;
    logic [31:0]   e;

    assign o_sts.walk_done = r_busy && (r_st == SW'(NST)) && (r_v == VW'(VOICES - 1));
    assign o_out_valid = r_ov;
    assign o_sample = r_os;
    assign four_i = {r_idx, 2'b00};
    assign t_wide = {1'b0, four_i[IW-1:0], 16'd0} >> IW;
    assign t_raw = t_wide[16:0];
    assign e = r_cnt - r_rtime[r_v];

    always_comb begin
        m1 = 34'(r_t2) * 34'd4640;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rel_len <= RELEASE_RESET;
            r_cnt <= '0;
            r_open <= '0;
            r_held <= '0;
            r_busy <= 1'b0;
            r_ov <= 1'b0;
            for (int v = 0; v < VOICES; v++) begin
                r_note[v] <= SILENT_NOTE;
                r_rtime[v] <= '0;
            end
        end else begin
            if (i_cfg_we) r_rel_len <= i_cfg_data;
            if (r_ov && i_out_ready) r_ov <= 1'b0;
            if (i_cmd.load) r_knote <= note_of_key(i_key_code);
            if (i_cmd.press) begin : press_blk
                logic found;
                found = 1'b0;
                for (int v = 0; v < VOICES; v++) begin
                    if (!found && (!r_open[v] || r_note[v] == r_knote)) begin
                        found = 1'b1;
                        r_open[v] <= 1'b1;
                        r_held[v] <= 1'b1;
                        r_note[v] <= r_knote;
                    end
                end
            end
            if (i_cmd.release_k) begin
                for (int v = 0; v < VOICES; v++) begin
                    if (r_note[v] == r_knote) begin
                        r_held[v] <= 1'b0;
                        r_rtime[v] <= r_cnt;
                    end
                end
            end
            if (i_cmd.clr_sum) r_sum <= '0;
            if (i_cmd.v_start) begin
                r_busy <= 1'b1;
                r_v <= '0;
                r_st <= '0;
            end
            if (r_busy) begin
                r_st <= r_st + SW'(1);
                case (r_st)
                    SW'(0): begin
                        r_inc <= INC_TAB[r_note[r_v]];
                        r_act <= r_open[r_v];
                        r_hld <= r_held[r_v];
                        r_dead <= (e >= {16'd0, r_rel_len});
                        r_g <= r_rel_len - e[15:0];
                    end
                    SW'(1): begin
                        r_ph <= r_cnt * r_inc;
                    end
                    SW'(2): begin
                        r_idx <= r_ph[31 -: IW];
                        r_q <= r_ph[31 -: 2];
                    end
                    SW'(3): begin
                        r_t <= r_q[0] ? (17'd65536 - t_raw) : t_raw;
                        r_t2 <= 17'((34'(r_q[0] ? (17'd65536 - t_raw) : t_raw)
                                * 34'(r_q[0] ? (17'd65536 - t_raw) : t_raw)) >> 16);
                    end
                    SW'(4): begin
                        r_r <= 17'((34'(17'd42047 - 17'(m1 >> 16)) * 34'(r_t2)) >> 16);
                    end
                    SW'(5): begin : sin_blk
                        logic [33:0] p;
                        logic [17:0] s;
                        p = 34'(17'd102944 - r_r) * 34'(r_t);
                        s = 18'(((p >> 16) + 34'd8) >> 4);
                        if (s > 18'd4096) s = 18'd4096;
                        r_s <= r_q[1] ? -14'(s) : 14'(s);
                    end
                    SW'(6): begin : mag_blk
                        logic [12:0] sm;
                        sm = r_s[13] ? 13'(-r_s) : 13'(r_s);
                        r_rem <= 29'(sm) * 29'(r_g);
                        r_neg <= r_s[13];
                        r_dsh <= {1'b0, r_rel_len, 12'd0};
                        r_quo <= '0;
                        r_dk <= 4'd12;
                    end
                    SW'(7): begin
                        if (r_rem >= r_dsh) r_rem <= r_rem - r_dsh;
                        r_quo <= {r_quo[11:0], (r_rem >= r_dsh)};
                        r_dsh <= r_dsh >> 1;
                        if (r_dk != 4'd0) begin
                            r_dk <= r_dk - 4'd1;
                            r_st <= r_st;
                        end
                    end
                    SW'(8): begin : mix_blk
                        logic signed [31:0] c;
                        c = '0;
                        if (r_act) begin
                            if (r_hld) c = 32'(r_s / 14'sd2);
                            else if (r_dead) r_open[r_v] <= 1'b0;
                            else c = r_neg ? -32'(r_quo) : 32'(r_quo);
                        end
                        r_sum <= r_sum + 21'(c);
                        r_st <= '0;
                        if (r_v == VW'(VOICES - 1)) r_busy <= 1'b0;
                        else r_v <= r_v + VW'(1);
                    end
                    default: r_st <= '0;
                endcase
            end
            if (i_cmd.finish) begin
                r_ov <= 1'b1;
                r_os <= (r_sum > 21'sd4096) ? 17'd4096 :
                        (r_sum < -21'sd65536) ? 17'h10000 : r_sum[16:0];
                r_cnt <= r_cnt + 32'd1;
            end
        end
    end

    `ASSERT_IMPL(a_walk_range, i_clk, i_rst_n, !r_busy || (r_v <= VW'(VOICES - 1)))
    `ASSERT_NEXT(a_fin_valid, i_clk, i_rst_n, i_cmd.finish, r_ov)
    `ASSERT_IMPL(a_no_clash, i_clk, i_rst_n, !(i_cmd.finish && r_busy))
endmodule

// File: sv/polyphonic_sine_voice_mixer.sv
// Ten-voice sine synthesizer: a key press or release is applied from a decode state; a
// sample tick walks the voices one at a time through a shared sine and gain unit, its length
// set by the shift-and-subtract divide of the fade gain in each voice. The result waits in an
// output register; the next request is taken once it has been loaded there, and a tick holds
// in its last step while an earlier sample is still waiting.
module polyphonic_sine_voice_mixer #(
    parameter int VOICES = psvm_pkg::VOICES_DEF,
    parameter int SINE_ENTRIES = psvm_pkg::SINE_ENTRIES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    psvm_if.sink        in_ch,
    psvm_if.source      out_ch,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data
);
    import psvm_pkg::*;

    t_cmd cmd;
    t_sts sts;
    t_req req;
    t_res res;

    assign req = t_req'(in_ch.data);
    assign out_ch.data = res;

    psvm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .o_in_ready(in_ch.ready),
        .i_op(req.op), .i_out_busy(out_ch.valid && !out_ch.ready),
        .i_sts(sts), .o_cmd(cmd)
    );

    psvm_dp #(.VOICES(VOICES), .SINE_ENTRIES(SINE_ENTRIES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_key_code(req.key_code), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_out_ready(out_ch.ready), .o_out_valid(out_ch.valid),
        .o_sample(res.sample), .o_sts(sts)
    );
endmodule
